[design/nsc_pkg.sv]
// Package for the NMEA sentence checksum checker.
// Holds the scan state type, verdict codes and character constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_UNCHECKED = 3'd1,
        VERDICT_BAD_START = 3'd2,
        VERDICT_SHORT_SUM = 3'd3,
        VERDICT_BAD_HEX   = 3'd4,
        VERDICT_MISMATCH  = 3'd5,
        VERDICT_NO_COMMA  = 3'd6
    } verdict_t;

    // Running state of one sentence, as it stands after each character.
    typedef struct packed {
        logic        first_seen;
        logic        starts_with_dollar;
        logic [1:0]  trimmed_length;
        logic [7:0]  running_xor;
        logic [7:0]  pending_space_xor;
        logic [1:0]  pending_space_count;
        logic        star_seen;
        logic [7:0]  xor_at_star;
        logic        comma_seen;
        logic        comma_before_star;
        logic [1:0]  after_star_count;
        logic [15:0] hex_digits;
    } nsc_state_t;

    // Characters collected after the last star.
    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] digits;
    } after_star_t;

    localparam nsc_state_t STATE_RESET = '0;

endpackage

`default_nettype wire

[design/nsc_scan.sv]
// Sentence scanner: holds the per-sentence state and works out its next value.
// Depends on nsc_pkg.
`default_nettype none

module nsc_scan
    import nsc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] char_in,
    input  wire logic       last_char,
    output nsc_state_t      state_next
);

    nsc_state_t  state_reg;
    after_star_t after_work;
    logic        blank;
    logic [2:0]  length_sum;

    function automatic after_star_t push_after_star(after_star_t a, logic [7:0] c);
        after_star_t r;
        r = a;
        if (a.count == 2'd0) begin
            r.digits = {8'h00, c};
            r.count  = 2'd1;
        end else if (a.count == 2'd1) begin
            r.digits = {c, a.digits[7:0]};
            r.count  = 2'd2;
        end
        return r;
    endfunction

    assign blank = (char_in == CH_CR) || (char_in == CH_LF) || (char_in == CH_SPACE);

    always_comb begin
        state_next = state_reg;
        after_work = '{count: state_reg.after_star_count, digits: state_reg.hex_digits};
        length_sum = 3'(state_reg.trimmed_length) + 3'(state_reg.pending_space_count) + 3'd1;
        if (!state_reg.first_seen) begin
            state_next.first_seen         = 1'b1;
            state_next.starts_with_dollar = (char_in == CH_DOLLAR);
            state_next.trimmed_length     = blank ? 2'd0 : 2'd1;
        end else if (blank) begin
            // Blanks are held back until a later character shows they are not trailing.
            state_next.pending_space_xor = state_reg.pending_space_xor ^ char_in;
            if (state_reg.pending_space_count != 2'd3) begin
                state_next.pending_space_count = state_reg.pending_space_count + 2'd1;
            end
        end else begin
            state_next.running_xor    = state_reg.running_xor ^ state_reg.pending_space_xor;
            state_next.trimmed_length = (length_sum >= 3'd2) ? 2'd2 : length_sum[1:0];
            for (int k = 0; k < 3; k++) begin
                if (state_reg.star_seen && (2'(k) < state_reg.pending_space_count)) begin
                    after_work = push_after_star(after_work, CH_SPACE);
                end
            end
            state_next.pending_space_xor   = 8'h00;
            state_next.pending_space_count = 2'd0;
            if (char_in == CH_COMMA) begin
                state_next.comma_seen = 1'b1;
            end
            if (char_in == CH_STAR) begin
                state_next.star_seen         = 1'b1;
                state_next.xor_at_star       = state_next.running_xor;
                state_next.comma_before_star = state_reg.comma_seen;
                after_work                   = '0;
            end else if (state_reg.star_seen) begin
                after_work = push_after_star(after_work, char_in);
            end
            state_next.after_star_count = after_work.count;
            state_next.hex_digits       = after_work.digits;
            state_next.running_xor      = state_next.running_xor ^ char_in;
        end
    end

    // The final character of a sentence returns the scanner to its reset state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (accept) begin
            state_reg <= last_char ? STATE_RESET : state_next;
        end
    end

endmodule

`default_nettype wire

[design/nsc_judge.sv]
// Verdict logic: turns the scan state after the final character into a result.
// Depends on nsc_pkg.
`default_nettype none

module nsc_judge
    import nsc_pkg::*;
(
    input  wire nsc_state_t state,
    output verdict_t        verdict,
    output logic [7:0]      computed_sum,
    output logic [7:0]      received_sum
);

    logic [4:0] h1;
    logic [4:0] h2;

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b0, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b0, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

    assign h1 = hex_value(state.hex_digits[7:0]);
    assign h2 = hex_value(state.hex_digits[15:8]);

    always_comb begin
        verdict      = VERDICT_BAD_START;
        computed_sum = 8'h00;
        received_sum = 8'h00;
        if (!state.starts_with_dollar || state.trimmed_length < 2'd2) begin
            verdict = VERDICT_BAD_START;
        end else if (state.star_seen) begin
            computed_sum = state.xor_at_star;
            if (state.after_star_count < 2'd2) begin
                verdict = VERDICT_SHORT_SUM;
            end else if (h1[4]) begin
                verdict = VERDICT_BAD_HEX;
            end else begin
                // A hex digit followed by a non-hex character stands alone as the sum.
                received_sum = h2[4] ? {4'h0, h1[3:0]} : {h1[3:0], h2[3:0]};
                if (received_sum != computed_sum) begin
                    verdict = VERDICT_MISMATCH;
                end else if (!state.comma_before_star) begin
                    verdict = VERDICT_NO_COMMA;
                end else begin
                    verdict = VERDICT_OK;
                end
            end
        end else begin
            verdict = state.comma_seen ? VERDICT_UNCHECKED : VERDICT_NO_COMMA;
        end
    end

endmodule

`default_nettype wire

[design/nmea_sentence_checksum_check_core.sv]
// Top level of the NMEA sentence checksum checker.
// Depends on nsc_pkg, nsc_scan and nsc_judge.
`default_nettype none

// Checks raw NMEA 0183 sentences fed one character per transaction, with
// s_last_char marking the final character. One character is taken every clock
// cycle while s_ready is high; the per-sentence state is a single register in
// the scanner, and its update loop is what sets the rate. The final character
// produces one result transaction from a register loaded at the edge that
// accepts it, so m_valid is high from that edge until the result is taken.
// s_ready is low only while a result is held and m_ready is low. Trailing CR,
// LF and space characters are ignored; the checksum covers the characters
// between the '$' and the last '*'.
module nmea_sentence_checksum_check_core
    import nsc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_last_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_verdict,
    output logic [7:0]      m_computed_sum,
    output logic [7:0]      m_received_sum
);

    nsc_state_t state_next;
    verdict_t   verdict;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       accept;

    logic       m_valid_reg;
    verdict_t   m_verdict_reg;
    logic [7:0] m_computed_sum_reg;
    logic [7:0] m_received_sum_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    nsc_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .char_in    (s_char_in),
        .last_char  (s_last_char),
        .state_next (state_next)
    );

    nsc_judge u_judge (
        .state        (state_next),
        .verdict      (verdict),
        .computed_sum (computed_sum),
        .received_sum (received_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_last_char) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_char) begin
            m_verdict_reg      <= verdict;
            m_computed_sum_reg <= computed_sum;
            m_received_sum_reg <= received_sum;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_verdict      = m_verdict_reg;
    assign m_computed_sum = m_computed_sum_reg;
    assign m_received_sum = m_received_sum_reg;

endmodule

`default_nettype wire

[bench/tb_nmea_sentence_checksum_check_core.sv]
// Self-checking testbench for nmea_sentence_checksum_check_core.
// Streams sentence characters, predicts each verdict or takes it from a table, and compares every result.
// Depends on nsc_pkg and the RTL of the block.
module tb_nmea_sentence_checksum_check_core;
    import nsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int ITEM_TARGET  = 1700;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int NOT_HEX      = 16;
    localparam int DIR_ROWS     = 9;
    // A string literal cannot hold a NUL byte, so the table uses this mark for one.
    localparam logic [7:0] NUL_MARK = "#";

    typedef struct packed {
        verdict_t   verdict;
        logic [7:0] computed;
        logic [7:0] received;
    } sum_check_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       s_last_char = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_verdict;
    logic [7:0] m_computed_sum;
    logic [7:0] m_received_sum;

    sum_check_t awaited_verdicts[$];
    logic [7:0] sentence_bytes[$];
    int         mismatch_count = 0;
    int         stim_count = 0;
    int         cycle_count = 0;
    bit         send_idle_on = 1'b1;
    bit         recv_idle_on = 1'b1;
    bit         long_hold_req = 1'b0;

    // Predictor copy of the per-sentence scan state.
    logic        got_first;
    logic        dollar_start;
    logic [1:0]  len_sat;
    logic [7:0]  body_xor;
    logic [7:0]  blank_xor;
    logic [1:0]  blank_cnt;
    logic        star_found;
    logic [7:0]  star_xor;
    logic        comma_found;
    logic        comma_pre_star;
    logic [1:0]  tail_cnt;
    logic [15:0] tail_bytes;

    string dir_text [DIR_ROWS] = '{
        "$", "#,", "$,", "$A", "$,*", "$,*G0", "$,*2X", "$,*2c\r", "$\377**D5\n"
    };
    bit dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 1, 1, 0};
    sum_check_t dir_expect [DIR_ROWS] = '{
        '{VERDICT_BAD_START, 8'h00, 8'h00},
        '{VERDICT_BAD_START, 8'h00, 8'h00},
        '{VERDICT_UNCHECKED, 8'h00, 8'h00},
        '{VERDICT_NO_COMMA,  8'h00, 8'h00},
        '{VERDICT_SHORT_SUM, 8'h2C, 8'h00},
        '{VERDICT_BAD_HEX,   8'h2C, 8'h00},
        '{VERDICT_MISMATCH,  8'h2C, 8'h02},
        '{VERDICT_OK,        8'h2C, 8'h2C},
        '{VERDICT_OK,        8'h00, 8'h00}
    };

    nmea_sentence_checksum_check_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .s_last_char    (s_last_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_computed_sum (m_computed_sum),
        .m_received_sum (m_received_sum)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic bit is_blank_char(input logic [7:0] c);
        return c == CH_CR || c == CH_LF || c == CH_SPACE;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return NOT_HEX;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'("0" + v);
        if ($urandom_range(0, 1) != 0) return 8'("a" + v - 10);
        return 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) != NOT_HEX);
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 2))
            0: return CH_CR;
            1: return CH_LF;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] body_char();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 4) return CH_COMMA;
        if (pick == 4) return CH_STAR;
        if (pick == 5) return blank_char();
        if (pick == 6) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic clear_scan();
        got_first      = 1'b0;
        dollar_start   = 1'b0;
        len_sat        = 2'd0;
        body_xor       = 8'h00;
        blank_xor      = 8'h00;
        blank_cnt      = 2'd0;
        star_found     = 1'b0;
        star_xor       = 8'h00;
        comma_found    = 1'b0;
        comma_pre_star = 1'b0;
        tail_cnt       = 2'd0;
        tail_bytes     = 16'h0000;
    endtask

    task automatic push_tail(input logic [7:0] c);
        if (tail_cnt == 2'd0) begin
            tail_bytes = {8'h00, c};
            tail_cnt   = 2'd1;
        end else if (tail_cnt == 2'd1) begin
            tail_bytes[15:8] = c;
            tail_cnt         = 2'd2;
        end
    endtask

    // Blanks are held back until a later non-blank character shows they are not trailing.
    task automatic scan_sentence_char(input logic [7:0] c, input bit last,
                                      output bit produced, output sum_check_t res);
        int h1;
        int h2;
        int k;
        produced = 1'b0;
        res = '{VERDICT_OK, 8'h00, 8'h00};
        if (!got_first) begin
            got_first    = 1'b1;
            dollar_start = (c == CH_DOLLAR);
            len_sat      = is_blank_char(c) ? 2'd0 : 2'd1;
        end else if (is_blank_char(c)) begin
            blank_xor ^= c;
            if (blank_cnt < 2'd3) blank_cnt++;
        end else begin
            body_xor ^= blank_xor;
            for (k = 0; k < int'(blank_cnt); k++) begin
                if (len_sat < 2'd2) len_sat++;
                if (star_found) push_tail(CH_SPACE);
            end
            blank_xor = 8'h00;
            blank_cnt = 2'd0;
            if (len_sat < 2'd2) len_sat++;
            if (c == CH_COMMA) comma_found = 1'b1;
            if (c == CH_STAR) begin
                star_found     = 1'b1;
                star_xor       = body_xor;
                comma_pre_star = comma_found;
                tail_cnt       = 2'd0;
                tail_bytes     = 16'h0000;
            end else if (star_found) begin
                push_tail(c);
            end
            body_xor ^= c;
        end
        if (last) begin
            produced = 1'b1;
            if (!dollar_start || len_sat < 2'd2) begin
                res.verdict = VERDICT_BAD_START;
            end else if (star_found) begin
                h1 = hex_nibble(tail_bytes[7:0]);
                h2 = hex_nibble(tail_bytes[15:8]);
                res.computed = star_xor;
                if (tail_cnt < 2'd2) begin
                    res.verdict = VERDICT_SHORT_SUM;
                end else if (h1 == NOT_HEX) begin
                    res.verdict = VERDICT_BAD_HEX;
                end else begin
                    res.received = (h2 != NOT_HEX) ? 8'(h1 * 16 + h2) : 8'(h1);
                    if (res.received != star_xor) res.verdict = VERDICT_MISMATCH;
                    else if (!comma_pre_star) res.verdict = VERDICT_NO_COMMA;
                    else res.verdict = VERDICT_OK;
                end
            end else begin
                res.verdict = comma_found ? VERDICT_UNCHECKED : VERDICT_NO_COMMA;
            end
            clear_scan();
        end
    endtask

    task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                             input sum_check_t typed_result);
        int gap;
        bit produced;
        sum_check_t predicted;
        gap = send_idle_on ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_in   <= c;
        s_last_char <= last;
        do @(posedge aclk); while (!s_ready);
        stim_count++;
        scan_sentence_char(c, last, produced, predicted);
        if (produced)
            awaited_verdicts.insert(awaited_verdicts.size(), typed ? typed_result : predicted);
    endtask

    // Mostly well-formed sentences with random bodies; the rest is noise or broken.
    task automatic make_sentence();
        int kind;
        int n;
        int k;
        logic [7:0] c;
        logic [7:0] sum;
        sentence_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++)
                sentence_bytes.insert(sentence_bytes.size(), 8'($urandom_range(0, 255)));
        end else begin
            if (kind < 13) begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_DOLLAR);
                sentence_bytes.insert(sentence_bytes.size(), c);
            end else begin
                sentence_bytes.insert(sentence_bytes.size(), CH_DOLLAR);
            end
            sum = 8'h00;
            n = $urandom_range(0, 9);
            for (k = 0; k < n; k++) begin
                c = body_char();
                sentence_bytes.insert(sentence_bytes.size(), c);
                sum ^= c;
            end
            if ($urandom_range(0, 4) != 0) begin
                sentence_bytes.insert(sentence_bytes.size(), CH_STAR);
                case ($urandom_range(0, 15))
                    0: begin
                        sum = 8'($urandom_range(0, 255));
                        sentence_bytes.insert(sentence_bytes.size(), hex_char(sum[7:4]));
                        sentence_bytes.insert(sentence_bytes.size(), hex_char(sum[3:0]));
                    end
                    1: ;
                    2: sentence_bytes.insert(sentence_bytes.size(), hex_char(sum[7:4]));
                    3: begin
                        sentence_bytes.insert(sentence_bytes.size(), non_hex_char());
                        sentence_bytes.insert(sentence_bytes.size(), hex_char(sum[3:0]));
                    end
                    4: begin
                        sentence_bytes.insert(sentence_bytes.size(), hex_char(sum[3:0]));
                        sentence_bytes.insert(sentence_bytes.size(), non_hex_char());
                    end
                    5: begin
                        sentence_bytes.insert(sentence_bytes.size(), CH_SPACE);
                        sentence_bytes.insert(sentence_bytes.size(), hex_char(sum[7:4]));
                    end
                    default: begin
                        sentence_bytes.insert(sentence_bytes.size(), hex_char(sum[7:4]));
                        sentence_bytes.insert(sentence_bytes.size(), hex_char(sum[3:0]));
                    end
                endcase
            end
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++) sentence_bytes.insert(sentence_bytes.size(), blank_char());
        end
    endtask

    task automatic send_sentence();
        int i;
        make_sentence();
        for (i = 0; i < sentence_bytes.size(); i++)
            send_char(sentence_bytes[i], i == sentence_bytes.size() - 1, 1'b0, '0);
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_verdicts.size() != 0);
    endtask

    initial begin : result_sink
        int gap;
        int held;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
                long_hold_req = 1'b0;
            end else begin
                gap = recv_idle_on ? $urandom_range(0, 13) : 0;
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_check
        sum_check_t wanted;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_verdicts.size() == 0) begin
                report_mismatch($sformatf("result transaction with none expected, verdict %0d",
                                          m_verdict));
            end else begin
                wanted = awaited_verdicts.pop_front();
                if (m_verdict !== wanted.verdict)
                    report_mismatch($sformatf("verdict %0d, expected %0d",
                                              m_verdict, wanted.verdict));
                if (m_computed_sum !== wanted.computed)
                    report_mismatch($sformatf("computed_sum %h, expected %h",
                                              m_computed_sum, wanted.computed));
                if (m_received_sum !== wanted.received)
                    report_mismatch($sformatf("received_sum %h, expected %h",
                                              m_received_sum, wanted.received));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL nmea_sentence_checksum_check_core");
        $finish;
    end

    initial begin : stimulus
        int r;
        int i;
        int s;
        logic [7:0] c;
        clear_scan();
        while (!aresetn) @(posedge aclk);

        for (r = 0; r < DIR_ROWS; r++) begin
            for (i = 0; i < dir_text[r].len(); i++) begin
                c = dir_text[r][i];
                if (c == NUL_MARK) c = 8'h00;
                send_char(c, i == dir_text[r].len() - 1, dir_typed[r], dir_expect[r]);
            end
        end
        pause_until_drained();

        // The sink holds off for a long stretch while characters keep coming, so the
        // held result backs up into the input.
        send_idle_on  = 1'b0;
        long_hold_req = 1'b1;
        repeat (16) send_sentence();
        pause_until_drained();

        s = 0;
        while (stim_count < ITEM_TARGET) begin
            if (s % 12 == 0) begin
                send_idle_on = $urandom_range(0, 3) != 0;
                recv_idle_on = $urandom_range(0, 3) != 0;
            end
            send_sentence();
            s++;
            if (s == 60) pause_until_drained();
        end
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && awaited_verdicts.size() == 0)
            $display("PASS nmea_sentence_checksum_check_core");
        else
            $display("FAIL nmea_sentence_checksum_check_core");
        $finish;
    end

endmodule

[filelist.f]
design/nsc_pkg.sv
design/nsc_scan.sv
design/nsc_judge.sv
design/nmea_sentence_checksum_check_core.sv
bench/tb_nmea_sentence_checksum_check_core.sv
